// File: hw/rtl/stq_pkg.sv
// Package for the sorted timer queue: field widths, request, command and
// status codes, and the command and status structs between controller and datapath.
// Depends on nothing.
`default_nettype none

package stq_pkg;

  localparam int KEY_W      = 16;
  localparam int TIME_W     = 32;
  localparam int SLOTS_DEF  = 16;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_EXPIRE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  localparam logic [1:0] CMD_LEAVE   = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_STOP    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NOKEY = 2'd3;

  typedef struct packed {
    logic load;
    logic scan;
    logic tail;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/stq_req_if.sv
// Request channel of the sorted timer queue: valid, ready and one request item.
// Depends on stq_pkg for the field widths.
`default_nettype none

interface stq_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [stq_pkg::KEY_W-1:0]  timer_key;
  logic [stq_pkg::TIME_W-1:0] duration;
  logic [stq_pkg::TIME_W-1:0] now;

  modport source (output valid, req_type, timer_key, duration, now, input ready);
  modport sink   (input valid, req_type, timer_key, duration, now, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/stq_rsp_if.sv
// Response channel of the sorted timer queue: valid, ready and one result item.
// Depends on stq_pkg for the field widths.
`default_nettype none

interface stq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       fired;
  logic [stq_pkg::KEY_W-1:0]  fired_key;
  logic [1:0]                 timer_cmd;
  logic [stq_pkg::TIME_W-1:0] timer_delay;
  logic [1:0]                 status;

  modport source (output valid, fired, fired_key, timer_cmd, timer_delay, status,
                  input ready);
  modport sink   (input valid, fired, fired_key, timer_cmd, timer_delay, status,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/stq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/stq_ctrl.sv
// Controller of the sorted timer queue: sequences load, slot scan, tail and result.
// Depends on stq_pkg for the command and status structs.
`default_nettype none

module stq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire stq_pkg::dp_sts_t sts_i,
  output stq_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_RESP
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan = (state_q == S_SCAN);
    cmd_o.tail = (state_q == S_TAIL);
    cmd_o.emit = (state_q == S_RESP) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (sts_i.scan_done) state_q <= S_TAIL;
        end
        S_TAIL: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/stq_dp.sv
// Datapath of the sorted timer queue: slot RAM, streaming insert and remove,
// fill count, result computation and the output register.
// Depends on stq_pkg and stq_ram.
`default_nettype none

module stq_dp #(
  parameter int TIMER_SLOTS = stq_pkg::SLOTS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire stq_pkg::dp_cmd_t           cmd_i,
  output stq_pkg::dp_sts_t                sts_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [stq_pkg::KEY_W-1:0]  timer_key_i,
  input  wire logic [stq_pkg::TIME_W-1:0] duration_i,
  input  wire logic [stq_pkg::TIME_W-1:0] now_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic                            fired_o,
  output logic      [stq_pkg::KEY_W-1:0]  fired_key_o,
  output logic      [1:0]                 timer_cmd_o,
  output logic      [stq_pkg::TIME_W-1:0] timer_delay_o,
  output logic      [1:0]                 status_o
);

  localparam int KW = stq_pkg::KEY_W;
  localparam int TW = stq_pkg::TIME_W;
  localparam int EW = KW + TW;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  logic [CW-1:0] count_q, count_d;
  logic          run_q;
  logic [CW-1:0] rd_idx_q;
  logic          rd_vld_q;
  logic [CW-1:0] rd_j_q;
  logic          out_vld_q;

  logic [1:0]    req_q;
  logic [KW-1:0] key_q;
  logic [TW-1:0] dl_q;
  logic [TW-1:0] now_q;
  logic          placed_q, found_q, pos0_q;
  logic [EW-1:0] carry_q;
  logic [TW-1:0] head_q, next_head_q;
  logic [KW-1:0] fkey_q;

  logic          res_fired_q;
  logic [KW-1:0] res_fkey_q;
  logic [1:0]    res_cmd_q, res_status_q;
  logic [TW-1:0] res_delay_q;
  logic          res_fired_d;
  logic [KW-1:0] res_fkey_d;
  logic [1:0]    res_cmd_d, res_status_d;

  logic          out_fired_q;
  logic [KW-1:0] out_fkey_q;
  logic [1:0]    out_cmd_q, out_status_q;
  logic [TW-1:0] out_delay_q;

  logic [TW:0]   sum;
  logic [TW-1:0] new_dl;
  logic          run_d;
  logic          rd_en;
  logic [EW-1:0] rdata;
  logic [KW-1:0] e_key;
  logic [TW-1:0] e_dl;
  logic          is_start;
  logic          hit;
  logic          match;
  logic [CW-1:0] jm1;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [TW-1:0] head_sel;
  logic [TW-1:0] delay;

  assign sum    = {1'b0, now_i} + {1'b0, duration_i};
  assign new_dl = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

  always_comb begin
    case (req_type_i)
      stq_pkg::REQ_START:  run_d = (count_q != CW'(TIMER_SLOTS));
      stq_pkg::REQ_CANCEL: run_d = 1'b1;
      stq_pkg::REQ_EXPIRE: run_d = (count_q != '0);
      default:             run_d = 1'b0;
    endcase
  end

  assign rd_en    = cmd_i.scan && run_q && (rd_idx_q != count_q);
  assign e_key    = rdata[EW-1:TW];
  assign e_dl     = rdata[TW-1:0];
  assign is_start = (req_q == stq_pkg::REQ_START);
  assign hit      = placed_q || (e_dl >= dl_q);
  assign match    = (req_q == stq_pkg::REQ_EXPIRE) ? (rd_j_q == '0) : (e_key == key_q);
  assign jm1      = rd_j_q - CW'(1);

  always_comb begin
    we    = 1'b0;
    waddr = rd_j_q[AW-1:0];
    wdata = carry_q;
    if (cmd_i.tail) begin
      we    = is_start && run_q;
      waddr = count_q[AW-1:0];
    end else if (rd_vld_q) begin
      if (is_start) begin
        we = hit;
      end else begin
        we    = found_q;
        waddr = jm1[AW-1:0];
        wdata = rdata;
      end
    end
  end

  stq_ram #(
    .WIDTH (EW),
    .DEPTH (TIMER_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    if (is_start) begin
      head_sel = ((count_q == '0) || (head_q >= dl_q)) ? dl_q : head_q;
    end else begin
      head_sel = next_head_q;
    end
  end

  assign delay = (head_sel > now_q) ? (head_sel - now_q) : '0;

  always_comb begin
    res_fired_d  = 1'b0;
    res_fkey_d   = '0;
    res_cmd_d    = stq_pkg::CMD_LEAVE;
    res_status_d = stq_pkg::ST_OK;
    count_d      = count_q;
    case (req_q)
      stq_pkg::REQ_START: begin
        if (!run_q) begin
          res_status_d = stq_pkg::ST_FULL;
        end else begin
          res_cmd_d = stq_pkg::CMD_RESTART;
          count_d   = count_q + CW'(1);
        end
      end
      stq_pkg::REQ_CANCEL: begin
        if (!found_q) begin
          res_status_d = stq_pkg::ST_NOKEY;
        end else begin
          count_d = count_q - CW'(1);
          if (pos0_q) begin
            res_cmd_d = (count_q > CW'(1)) ? stq_pkg::CMD_RESTART : stq_pkg::CMD_STOP;
          end
        end
      end
      stq_pkg::REQ_EXPIRE: begin
        if (!found_q) begin
          res_status_d = stq_pkg::ST_EMPTY;
        end else begin
          res_fired_d = 1'b1;
          res_fkey_d  = fkey_q;
          count_d     = count_q - CW'(1);
          res_cmd_d   = (count_q > CW'(1)) ? stq_pkg::CMD_RESTART : stq_pkg::CMD_STOP;
        end
      end
      default: begin
        res_status_d = stq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      run_q     <= 1'b0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (cmd_i.load) begin
        run_q    <= run_d;
        rd_idx_q <= '0;
      end else if (rd_en) begin
        rd_idx_q <= rd_idx_q + CW'(1);
      end
      if (cmd_i.tail) begin
        count_q <= count_d;
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_j_q <= rd_idx_q;
    if (cmd_i.load) begin
      req_q    <= req_type_i;
      key_q    <= timer_key_i;
      dl_q     <= new_dl;
      now_q    <= now_i;
      carry_q  <= {timer_key_i, new_dl};
      placed_q <= 1'b0;
      found_q  <= 1'b0;
      pos0_q   <= 1'b0;
    end else if (rd_vld_q) begin
      if (is_start) begin
        if (rd_j_q == '0) head_q <= e_dl;
        if (hit) begin
          carry_q  <= rdata;
          placed_q <= 1'b1;
        end
      end else begin
        if (rd_j_q == CW'(1)) next_head_q <= e_dl;
        if (!found_q && match) begin
          found_q <= 1'b1;
          pos0_q  <= (rd_j_q == '0);
          fkey_q  <= e_key;
        end
      end
    end
    if (cmd_i.tail) begin
      res_fired_q  <= res_fired_d;
      res_fkey_q   <= res_fkey_d;
      res_cmd_q    <= res_cmd_d;
      res_status_q <= res_status_d;
      res_delay_q  <= (res_cmd_d == stq_pkg::CMD_RESTART) ? delay : '0;
    end
    if (cmd_i.emit) begin
      out_fired_q  <= res_fired_q;
      out_fkey_q   <= res_fkey_q;
      out_cmd_q    <= res_cmd_q;
      out_status_q <= res_status_q;
      out_delay_q  <= res_delay_q;
    end
  end

  assign sts_o.scan_done = !rd_vld_q && (!run_q || (rd_idx_q == count_q));
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  assign out_valid_o   = out_vld_q;
  assign fired_o       = out_fired_q;
  assign fired_key_o   = out_fkey_q;
  assign timer_cmd_o   = out_cmd_q;
  assign timer_delay_o = out_delay_q;
  assign status_o      = out_status_q;

endmodule

`default_nettype wire

// File: hw/rtl/sorted_timer_queue.sv
// Sorted timer queue: an item passes the slot scan, the tail and the result states from
// acceptance to its result in the output register; the scan covers the N slots in use (at
// most TIMER_SLOTS), one slot per cycle through the slot RAM read port, and ignored, full
// and empty cases visit no slot. A new item is accepted at the edge after the previous
// result enters the output register, so an item is not taken before the last one is done.
// Reset clears the fill count and the control state; slot contents are left as they are.
`default_nettype none

module sorted_timer_queue #(
  parameter int TIMER_SLOTS = stq_pkg::SLOTS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  stq_req_if.sink    req_i,
  stq_rsp_if.source  rsp_o
);

  stq_pkg::dp_cmd_t cmd;
  stq_pkg::dp_sts_t sts;

  stq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stq_dp #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_i.req_type),
    .timer_key_i   (req_i.timer_key),
    .duration_i    (req_i.duration),
    .now_i         (req_i.now),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .fired_o       (rsp_o.fired),
    .fired_key_o   (rsp_o.fired_key),
    .timer_cmd_o   (rsp_o.timer_cmd),
    .timer_delay_o (rsp_o.timer_delay),
    .status_o      (rsp_o.status)
  );

endmodule

`default_nettype wire
